@@ hdl/igm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and the per-result context struct for the image gradient block.
// No dependencies; every other file imports it.
package igm_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_BITS      = 8;
    localparam int GRAD_BITS     = 10;
    localparam int EXT_BITS      = 11;
    localparam int FRAME_W_BITS  = 12;
    localparam int FRAME_H_BITS  = 16;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 64;

    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RST = 12'd2048;
    localparam logic [FRAME_H_BITS-1:0] FRAME_H_RST = 16'd1;

    // running extremes reload: min 256 and max -256 grey levels, in half units
    localparam logic signed [EXT_BITS-1:0] EXT_MIN_RST = 11'sd512;
    localparam logic signed [EXT_BITS-1:0] EXT_MAX_RST = -11'sd512;

    // register word index (paddr[3:2])
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BORDER_MODE  = 2'd2;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic BORDER_ONE_SIDED = 1'b0;
    localparam logic BORDER_REPLICATE = 1'b1;

    typedef struct packed {
        logic x_first;
        logic x_last;
        logic y_first;
        logic y_last;
        logic last_pix;
        logic border;
    } t_ctx;

endpackage

@@ hdl/image_gradient_minmax_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: two register stages (window read, output register) lie between the beat that
// releases a result and m_axis. A pixel's result is released frame_width + 1 pixels later,
// or by a flush beat at frame start. Throughput: one beat per clock on either side while m_axis
// is not stalled, set by the single read of the window store.
// Reset (synchronous, i_rst_n low) clears counters, pointers, extremes and valid flags;
// the window store is not cleared and no clearing pass is run.
// Uses igm_pkg, igm_win_mem and igm_grad_calc.
module image_gradient_minmax_unit #(
    parameter int MAX_WIDTH = igm_pkg::MAX_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [igm_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [igm_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [igm_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [igm_pkg::PIX_BITS-1:0]         s_axis_tdata,  // [7:0] pixel
    input  logic [0:0]                           s_axis_tuser,  // [0] mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [9:0] grad_x, [19:10] grad_y, [29:20] min_grad_x, [39:30] max_grad_x,
    // [49:40] min_grad_y, [59:50] max_grad_y, [63:60] zero
    output logic [igm_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    output logic                                 m_axis_tlast   // frame_last
);
    import igm_pkg::*;

    localparam int AW = $clog2(2*MAX_WIDTH+2);
    localparam int PW = $clog2(MAX_WIDTH+2);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = FRAME_H_BITS + 1;

    // configuration
    logic [FRAME_W_BITS-1:0] r_frame_width;
    logic [FRAME_H_BITS-1:0] r_frame_height;
    logic                    r_border;
    logic                    cfg_wr;

    // input side position and window pointers
    logic [AW-1:0] r_ws;
    logic [AW-1:0] r_rd;
    logic [PW-1:0] r_pending;
    logic [CW-1:0] r_col;
    logic [FRAME_H_BITS-1:0] r_row;
    logic [CW-1:0] r_ocol;
    logic [FRAME_H_BITS-1:0] r_orow;

    logic [31:0]   w_clamp;
    logic [AW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          in_acc;
    logic          is_flush;
    logic          wr_en;
    logic          emit;
    logic          col_wrap;
    logic          row_wrap;
    logic          ox_last;
    logic          oy_last;
    t_ctx          ctx;

    // stage 1 and output register
    logic          r_s1_valid;
    t_ctx          r_s1_ctx;
    logic          s1_adv;
    logic [PIX_BITS-1:0] r_prev_c;
    logic [PIX_BITS-1:0] pix_c;
    logic [PIX_BITS-1:0] pix_r;
    logic [PIX_BITS-1:0] pix_u;
    logic [PIX_BITS-1:0] pix_d;
    logic signed [GRAD_BITS-1:0] grad_x;
    logic signed [GRAD_BITS-1:0] grad_y;
    logic signed [EXT_BITS-1:0]  gx_e;
    logic signed [EXT_BITS-1:0]  gy_e;
    logic signed [EXT_BITS-1:0]  r_min_x;
    logic signed [EXT_BITS-1:0]  r_max_x;
    logic signed [EXT_BITS-1:0]  r_min_y;
    logic signed [EXT_BITS-1:0]  r_max_y;
    logic signed [EXT_BITS-1:0]  n_min_x;
    logic signed [EXT_BITS-1:0]  n_max_x;
    logic signed [EXT_BITS-1:0]  n_min_y;
    logic signed [EXT_BITS-1:0]  n_max_y;
    logic [OUT_DATA_BITS-1:0]    n_out_data;
    logic                        r_out_valid;
    logic [OUT_DATA_BITS-1:0]    r_out_data;
    logic                        r_out_last;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_W_RST;
            r_frame_height <= FRAME_H_RST;
            r_border       <= BORDER_ONE_SIDED;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FRAME_W_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FRAME_H_BITS-1:0];
                REG_BORDER_MODE:  r_border       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(r_frame_height);
            REG_BORDER_MODE:  prdata = APB_DATA_BITS'(r_border);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- geometry in use
    always_comb begin
        if (r_frame_width == '0) begin
            w_clamp = 32'd1;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_clamp = 32'(MAX_WIDTH);
        end else begin
            w_clamp = 32'(r_frame_width);
        end
    end
    assign w_eff = w_clamp[AW-1:0];
    assign h_eff = (r_frame_height == '0) ? HW'(1) : HW'(r_frame_height);

    // ---------------------------------------------------------------- stage 0
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_flush      = (s_axis_tuser[0] == MODE_FLUSH);
    assign wr_en         = in_acc && !is_flush;

    // a pixel releases the oldest result once more than frame_width are waiting;
    // a flush drains one only at the start of a frame
    assign emit = in_acc && (is_flush
                  ? (r_pending != '0 && r_col == '0 && r_row == '0)
                  : (AW'(r_pending) > w_eff));

    assign col_wrap = (AW'(r_col) + AW'(1)) >= w_eff;
    assign row_wrap = (HW'(r_row) + HW'(1)) >= h_eff;
    assign ox_last  = (AW'(r_ocol) + AW'(1)) >= w_eff;
    assign oy_last  = (HW'(r_orow) + HW'(1)) >= h_eff;

    always_comb begin
        ctx.x_first  = (r_ocol == '0) || (w_eff == AW'(1));
        ctx.x_last   = ox_last;
        ctx.y_first  = (r_orow == '0) || (h_eff == HW'(1));
        ctx.y_last   = oy_last;
        ctx.last_pix = ox_last && oy_last;
        ctx.border   = r_border;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws      <= '0;
            r_rd      <= '0;
            r_pending <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
        end else begin
            if (wr_en) begin
                r_ws <= r_ws + AW'(1);
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : r_row + FRAME_H_BITS'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (wr_en && !emit) begin
                r_pending <= r_pending + PW'(1);
            end else if (!wr_en && emit) begin
                r_pending <= r_pending - PW'(1);
            end
            if (emit) begin
                r_rd <= r_rd + AW'(1);
                if (ox_last) begin
                    r_ocol <= '0;
                    r_orow <= oy_last ? '0 : r_orow + FRAME_H_BITS'(1);
                end else begin
                    r_ocol <= r_ocol + CW'(1);
                end
            end
        end
    end

    // Reads on a pixel beat all lie behind the slot being written, so no forwarding is needed.
    igm_win_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_ws),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (emit),
        .i_addr_c  (r_rd),
        .i_addr_r  (r_rd + AW'(1)),
        .i_addr_u  (r_rd - w_eff),
        .i_addr_d  (r_rd + w_eff),
        .o_pix_c   (pix_c),
        .o_pix_r   (pix_r),
        .o_pix_u   (pix_u),
        .o_pix_d   (pix_d)
    );

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_s1_ctx <= ctx;
        end
        // results leave in raster order, so the last centre is the left neighbour
        if (s1_adv) begin
            r_prev_c <= pix_c;
        end
    end

    igm_grad_calc u_grad_calc (
        .i_ctx    (r_s1_ctx),
        .i_pix_c  (pix_c),
        .i_pix_l  (r_prev_c),
        .i_pix_r  (pix_r),
        .i_pix_u  (pix_u),
        .i_pix_d  (pix_d),
        .o_grad_x (grad_x),
        .o_grad_y (grad_y)
    );

    assign gx_e = EXT_BITS'(grad_x);
    assign gy_e = EXT_BITS'(grad_y);

    always_comb begin
        n_min_x = (gx_e < r_min_x) ? gx_e : r_min_x;
        n_max_x = (gx_e > r_max_x) ? gx_e : r_max_x;
        n_min_y = (gy_e < r_min_y) ? gy_e : r_min_y;
        n_max_y = (gy_e > r_max_y) ? gy_e : r_max_y;
        n_out_data = '0;
        n_out_data[9:0]   = grad_x;
        n_out_data[19:10] = grad_y;
        if (r_s1_ctx.last_pix) begin
            n_out_data[29:20] = n_min_x[GRAD_BITS-1:0];
            n_out_data[39:30] = n_max_x[GRAD_BITS-1:0];
            n_out_data[49:40] = n_min_y[GRAD_BITS-1:0];
            n_out_data[59:50] = n_max_y[GRAD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= EXT_MIN_RST;
            r_max_x <= EXT_MAX_RST;
            r_min_y <= EXT_MIN_RST;
            r_max_y <= EXT_MAX_RST;
        end else if (s1_adv) begin
            // reload after the frame's final result
            r_min_x <= r_s1_ctx.last_pix ? EXT_MIN_RST : n_min_x;
            r_max_x <= r_s1_ctx.last_pix ? EXT_MAX_RST : n_max_x;
            r_min_y <= r_s1_ctx.last_pix ? EXT_MIN_RST : n_min_y;
            r_max_y <= r_s1_ctx.last_pix ? EXT_MAX_RST : n_max_y;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_ctx.last_pix;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ hdl/igm_win_mem.sv @@
`timescale 1ns / 1ps
// Pixel window store: two copies of the circular pixel buffer, each with two read ports.
// Uses igm_pkg for pixel width; read data is registered.
module igm_win_mem #(
    parameter int MAX_WIDTH = igm_pkg::MAX_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [$clog2(2*MAX_WIDTH+2)-1:0]          i_wr_addr,
    input  logic [igm_pkg::PIX_BITS-1:0]              i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [$clog2(2*MAX_WIDTH+2)-1:0]          i_addr_c,
    input  logic [$clog2(2*MAX_WIDTH+2)-1:0]          i_addr_r,
    input  logic [$clog2(2*MAX_WIDTH+2)-1:0]          i_addr_u,
    input  logic [$clog2(2*MAX_WIDTH+2)-1:0]          i_addr_d,
    output logic [igm_pkg::PIX_BITS-1:0]              o_pix_c,
    output logic [igm_pkg::PIX_BITS-1:0]              o_pix_r,
    output logic [igm_pkg::PIX_BITS-1:0]              o_pix_u,
    output logic [igm_pkg::PIX_BITS-1:0]              o_pix_d
);
    import igm_pkg::*;

    localparam int AW    = $clog2(2*MAX_WIDTH+2);
    localparam int DEPTH = 2**AW;

    // row copy serves the centre and right neighbour, column copy the rows above and below
    logic [PIX_BITS-1:0] r_mem_row [DEPTH];
    logic [PIX_BITS-1:0] r_mem_col [DEPTH];
    logic [PIX_BITS-1:0] r_pix_c;
    logic [PIX_BITS-1:0] r_pix_r;
    logic [PIX_BITS-1:0] r_pix_u;
    logic [PIX_BITS-1:0] r_pix_d;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_row[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_pix_c <= r_mem_row[i_addr_c];
            r_pix_r <= r_mem_row[i_addr_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_col[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_pix_u <= r_mem_col[i_addr_u];
            r_pix_d <= r_mem_col[i_addr_d];
        end
    end

    assign o_pix_c = r_pix_c;
    assign o_pix_r = r_pix_r;
    assign o_pix_u = r_pix_u;
    assign o_pix_d = r_pix_d;

endmodule

@@ hdl/igm_grad_calc.sv @@
`timescale 1ns / 1ps
// Gradient arithmetic for one result: horizontal and vertical differences in half units.
// Uses igm_pkg for the context struct and border codes.
module igm_grad_calc (
    input  igm_pkg::t_ctx                        i_ctx,
    input  logic [igm_pkg::PIX_BITS-1:0]         i_pix_c,
    input  logic [igm_pkg::PIX_BITS-1:0]         i_pix_l,
    input  logic [igm_pkg::PIX_BITS-1:0]         i_pix_r,
    input  logic [igm_pkg::PIX_BITS-1:0]         i_pix_u,
    input  logic [igm_pkg::PIX_BITS-1:0]         i_pix_d,
    output logic signed [igm_pkg::GRAD_BITS-1:0] o_grad_x,
    output logic signed [igm_pkg::GRAD_BITS-1:0] o_grad_y
);
    import igm_pkg::*;

    function automatic logic signed [GRAD_BITS-1:0] axis_grad(
        input logic [PIX_BITS-1:0] lo_pix,
        input logic [PIX_BITS-1:0] c_pix,
        input logic [PIX_BITS-1:0] hi_pix,
        input logic                first,
        input logic                last,
        input logic                border
    );
        logic signed [GRAD_BITS-1:0] lo;
        logic signed [GRAD_BITS-1:0] hi;
        logic signed [GRAD_BITS-1:0] d;
        // replicate the centre pixel past either edge
        lo = first ? {2'b00, c_pix} : {2'b00, lo_pix};
        hi = last  ? {2'b00, c_pix} : {2'b00, hi_pix};
        d  = hi - lo;
        if (border == BORDER_ONE_SIDED && (first || last)) begin
            return {d[GRAD_BITS-2:0], 1'b0};
        end
        return d;
    endfunction

    assign o_grad_x = axis_grad(i_pix_l, i_pix_c, i_pix_r, i_ctx.x_first, i_ctx.x_last,
                                i_ctx.border);
    assign o_grad_y = axis_grad(i_pix_u, i_pix_c, i_pix_d, i_ctx.y_first, i_ctx.y_last,
                                i_ctx.border);

endmodule

@@ hdl/igm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the result stream of image_gradient_minmax_unit, bound to the top level.
// Uses igm_pkg for the output data width.
module igm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [igm_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    input logic                                 m_axis_tlast
);
    import igm_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // extremes fields are zero except on the frame's final beat
    a_ext_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[59:20] == '0)
        else $error("extremes present on a non-final beat");

    // final beat: frame extremes bracket its own gradients
    a_ext_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            $signed(m_axis_tdata[29:20]) <= $signed(m_axis_tdata[9:0]) &&
            $signed(m_axis_tdata[9:0])   <= $signed(m_axis_tdata[39:30]) &&
            $signed(m_axis_tdata[49:40]) <= $signed(m_axis_tdata[19:10]) &&
            $signed(m_axis_tdata[19:10]) <= $signed(m_axis_tdata[59:50]))
        else $error("frame extremes do not bracket final gradients");

    // gradients stay within half-unit range
    a_grad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[9:0])   >= -10'sd510 &&
            $signed(m_axis_tdata[9:0])   <=  10'sd510 &&
            $signed(m_axis_tdata[19:10]) >= -10'sd510 &&
            $signed(m_axis_tdata[19:10]) <=  10'sd510)
        else $error("gradient out of range");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

endmodule

bind image_gradient_minmax_unit igm_checker u_igm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
